>>> design/sdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdc_pkg
// Shared types, constants and helpers for the stick deadzone conditioner.
// ----------------------------------------------------------------------------
package sdc_pkg;

  // default sample width
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned CFG_W  = 15;
  localparam int unsigned OUT_W  = 16;
  localparam int unsigned ZONE_W = 2;
  localparam int unsigned CIDX_W = 3;

  // x * 32767 is done as (x << ONE_W) - x
  localparam int unsigned ONE_W = 15;

  // magnitude datapath: 62-bit radicand, 31-bit root, 15-bit quotients
  localparam int unsigned RAD_W  = 62;
  localparam int unsigned MAGQ_W = RAD_W / 2;
  localparam int unsigned QUO_W  = 15;

  localparam logic [OUT_W-1:0] ONE_Q  = 16'd32767;
  localparam logic [OUT_W-1:0] DIAG_Q = 16'd23170;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_IDX_MODE   = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_IDX_INNER  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_IDX_OUTER  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_IDX_RATIO  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_IDX_THRESH = 3'd4;

  // zone codes, radial mode
  localparam logic [ZONE_W-1:0] ZONE_DEAD   = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_SCALED = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_SAT    = 2'd2;
  // zone codes, eight-way mode
  localparam logic [ZONE_W-1:0] ZONE_NONE   = 2'd0;
  localparam logic [ZONE_W-1:0] ZONE_X      = 2'd1;
  localparam logic [ZONE_W-1:0] ZONE_Y      = 2'd2;
  localparam logic [ZONE_W-1:0] ZONE_DIAG   = 2'd3;

  typedef struct packed {
    logic             mode;
    logic [CFG_W-1:0] inner;
    logic [CFG_W-1:0] outer;
    logic [CFG_W-1:0] ratio;
    logic [CFG_W-1:0] thresh;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mode:   1'b0,
    inner:  15'd4096,
    outer:  15'd32439,
    ratio:  15'd13573,
    thresh: 15'd16384
  };

  // eight-way snap result
  typedef struct packed {
    logic [OUT_W-1:0]  x;
    logic [OUT_W-1:0]  y;
    logic [ZONE_W-1:0] zone;
  } ew_res_t;

  localparam int unsigned EW_W = $bits(ew_res_t);

  // two's complement negate when the sample was negative
  function automatic logic [OUT_W-1:0] apply_sign(input logic [OUT_W-1:0] mag,
                                                   input logic neg);
    return neg ? (~mag + 1'b1) : mag;
  endfunction

endpackage
`default_nettype wire

>>> design/sdc_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdc_isqrt
// Pipelined integer square root, one root bit per stage, with a sideband
// vector that travels alongside.
// ----------------------------------------------------------------------------
module sdc_isqrt #(
  parameter int unsigned RAD_W  = sdc_pkg::RAD_W,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [RAD_W-1:0]      rad_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  vld_o,
  output logic [RAD_W/2-1:0]    root_o,
  output logic [SIDE_W-1:0]     side_o
);
  import sdc_pkg::*;

  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned NST    = ROOT_W;

  logic                vld_q  [NST];
  logic [ROOT_W:0]     rem_q  [NST];
  logic [ROOT_W-1:0]   root_q [NST];
  logic [RAD_W-1:0]    rad_q  [NST];
  logic [SIDE_W-1:0]   side_q [NST];

  logic [ROOT_W:0]     rem_in  [NST];
  logic [ROOT_W-1:0]   root_in [NST];
  logic [RAD_W-1:0]    rad_in  [NST];
  logic [ROOT_W:0]     rem_d   [NST];
  logic [ROOT_W-1:0]   root_d  [NST];

  // one step: bring down two radicand bits, try (root << 2) | 1
  function automatic logic [2*ROOT_W:0] sqrt_step(input logic [ROOT_W:0] rem,
                                                  input logic [ROOT_W-1:0] root,
                                                  input logic [1:0] pair);
    logic [ROOT_W+2:0] t;
    logic [ROOT_W+2:0] trial;
    logic              rbit;
    t     = {rem, pair};
    trial = (ROOT_W+3)'({root, 2'b01});
    rbit  = 1'b0;
    if (t >= trial) begin
      t    = t - trial;
      rbit = 1'b1;
    end
    return {t[ROOT_W:0], root[ROOT_W-2:0], rbit};
  endfunction

  // stage inputs
  always_comb begin
    rem_in[0]  = '0;
    root_in[0] = '0;
    rad_in[0]  = rad_i;
    for (int i = 1; i < NST; i++) begin
      rem_in[i]  = rem_q[i-1];
      root_in[i] = root_q[i-1];
      rad_in[i]  = rad_q[i-1];
    end
    for (int i = 0; i < NST; i++) begin
      {rem_d[i], root_d[i]} = sqrt_step(rem_in[i], root_in[i],
                                        rad_in[i][RAD_W-1:RAD_W-2]);
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
      for (int i = 1; i < NST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
    for (int i = 1; i < NST; i++) side_q[i] <= side_q[i-1];
    for (int i = 0; i < NST; i++) begin
      rem_q[i]  <= rem_d[i];
      root_q[i] <= root_d[i];
      rad_q[i]  <= {rad_in[i][RAD_W-3:0], 2'b00};
    end
  end

  assign vld_o  = vld_q[NST-1];
  assign root_o = root_q[NST-1];
  assign side_o = side_q[NST-1];

endmodule
`default_nettype wire

>>> design/sdc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdc_div
// Pipelined restoring divider, two numerators over one shared denominator,
// one quotient bit per stage. Expects num < den << QUO_W.
// ----------------------------------------------------------------------------
module sdc_div #(
  parameter int unsigned NUM_W  = 46,
  parameter int unsigned DEN_W  = 31,
  parameter int unsigned QUO_W  = sdc_pkg::QUO_W,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_a_i,
  input  logic [NUM_W-1:0]  num_b_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [QUO_W-1:0]  quo_a_o,
  output logic [QUO_W-1:0]  quo_b_o,
  output logic [SIDE_W-1:0] side_o
);
  import sdc_pkg::*;

  logic              vld_q   [QUO_W];
  logic [DEN_W-1:0]  rem_a_q [QUO_W];
  logic [DEN_W-1:0]  rem_b_q [QUO_W];
  logic [QUO_W-1:0]  acc_a_q [QUO_W];
  logic [QUO_W-1:0]  acc_b_q [QUO_W];
  logic [DEN_W-1:0]  den_q   [QUO_W];
  logic [SIDE_W-1:0] side_q  [QUO_W];

  logic [DEN_W-1:0]  rem_a_in [QUO_W];
  logic [DEN_W-1:0]  rem_b_in [QUO_W];
  logic [QUO_W-1:0]  acc_a_in [QUO_W];
  logic [QUO_W-1:0]  acc_b_in [QUO_W];
  logic [DEN_W-1:0]  den_in   [QUO_W];
  logic [DEN_W-1:0]  rem_a_d  [QUO_W];
  logic [DEN_W-1:0]  rem_b_d  [QUO_W];
  logic [QUO_W-1:0]  acc_a_d  [QUO_W];
  logic [QUO_W-1:0]  acc_b_d  [QUO_W];

  // acc holds the numerator bits still to bring down; quotient bits fill in
  function automatic logic [DEN_W+QUO_W-1:0] div_step(input logic [DEN_W-1:0] rem,
                                                      input logic [QUO_W-1:0] acc,
                                                      input logic [DEN_W-1:0] den);
    logic [DEN_W:0] t;
    logic           qbit;
    t    = {rem, acc[QUO_W-1]};
    qbit = 1'b0;
    if (t >= {1'b0, den}) begin
      t    = t - {1'b0, den};
      qbit = 1'b1;
    end
    return {t[DEN_W-1:0], acc[QUO_W-2:0], qbit};
  endfunction

  always_comb begin
    rem_a_in[0] = DEN_W'(num_a_i[NUM_W-1:QUO_W]);
    rem_b_in[0] = DEN_W'(num_b_i[NUM_W-1:QUO_W]);
    acc_a_in[0] = num_a_i[QUO_W-1:0];
    acc_b_in[0] = num_b_i[QUO_W-1:0];
    den_in[0]   = den_i;
    for (int i = 1; i < QUO_W; i++) begin
      rem_a_in[i] = rem_a_q[i-1];
      rem_b_in[i] = rem_b_q[i-1];
      acc_a_in[i] = acc_a_q[i-1];
      acc_b_in[i] = acc_b_q[i-1];
      den_in[i]   = den_q[i-1];
    end
    for (int i = 0; i < QUO_W; i++) begin
      {rem_a_d[i], acc_a_d[i]} = div_step(rem_a_in[i], acc_a_in[i], den_in[i]);
      {rem_b_d[i], acc_b_d[i]} = div_step(rem_b_in[i], acc_b_in[i], den_in[i]);
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < QUO_W; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
      for (int i = 1; i < QUO_W; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    side_q[0] <= side_i;
    for (int i = 1; i < QUO_W; i++) side_q[i] <= side_q[i-1];
    for (int i = 0; i < QUO_W; i++) begin
      rem_a_q[i] <= rem_a_d[i];
      rem_b_q[i] <= rem_b_d[i];
      acc_a_q[i] <= acc_a_d[i];
      acc_b_q[i] <= acc_b_d[i];
      den_q[i]   <= den_in[i];
    end
  end

  assign vld_o   = vld_q[QUO_W-1];
  assign quo_a_o = acc_a_q[QUO_W-1];
  assign quo_b_o = acc_b_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule
`default_nettype wire

>>> design/sdc_eightway.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sdc_eightway
// Three-stage eight-way snap: ratio and threshold products, compares, then
// the axis / diagonal decision. Magnitudes and signs pass through.
// ----------------------------------------------------------------------------
module sdc_eightway #(
  parameter int unsigned SAMPLE_BITS = sdc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  logic [SAMPLE_BITS-1:0] ax_i,
  input  logic [SAMPLE_BITS-1:0] ay_i,
  input  logic                   nx_i,
  input  logic                   ny_i,
  input  sdc_pkg::cfg_t          cfg_i,
  output logic                   vld_o,
  output logic [SAMPLE_BITS-1:0] ax_o,
  output logic [SAMPLE_BITS-1:0] ay_o,
  output logic                   nx_o,
  output logic                   ny_o,
  output sdc_pkg::ew_res_t       res_o
);
  import sdc_pkg::*;

  localparam int unsigned SB   = SAMPLE_BITS;
  localparam int unsigned P_W  = SB + CFG_W;         // a * ratio, a * 32767
  localparam int unsigned U_W  = CFG_W + OUT_W;      // T * (32767 + r)
  localparam int unsigned TF_W = CFG_W + SB - 1;     // T * FS
  localparam int unsigned L_W  = SB + 2 * ONE_W + 1; // (ax + ay) * 32767^2
  localparam logic [SB-2:0] FS = '1;

  // stage 1 registers
  logic            s1_vld_q;
  logic [SB-1:0]   s1_ax_q, s1_ay_q;
  logic            s1_nx_q, s1_ny_q;
  logic [P_W-1:0]  s1_pxr_q, s1_pyr_q;
  logic [U_W-1:0]  s1_u_q;
  logic [TF_W-1:0] s1_tfs_q;
  logic [OUT_W-1:0] rsum;

  // stage 2 registers
  logic            s2_vld_q;
  logic [SB-1:0]   s2_ax_q, s2_ay_q;
  logic            s2_nx_q, s2_ny_q;
  logic            s2_xdom_q, s2_xthr_q, s2_ydom_q, s2_ythr_q, s2_diag_q;
  logic [P_W-1:0]  ax32, ay32;
  logic [SB:0]     asum;
  logic [L_W-1:0]  lhs, rhs;

  // stage 3 registers
  logic            s3_vld_q;
  logic [SB-1:0]   s3_ax_q, s3_ay_q;
  logic            s3_nx_q, s3_ny_q;
  ew_res_t         s3_res_q, s3_res_d;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // stage 1: products against the ratio and threshold
  assign rsum = ONE_Q + OUT_W'(cfg_i.ratio);

  always_ff @(posedge clk_i) begin
    s1_ax_q  <= ax_i;
    s1_ay_q  <= ay_i;
    s1_nx_q  <= nx_i;
    s1_ny_q  <= ny_i;
    s1_pxr_q <= P_W'(ax_i) * P_W'(cfg_i.ratio);
    s1_pyr_q <= P_W'(ay_i) * P_W'(cfg_i.ratio);
    s1_u_q   <= U_W'(cfg_i.thresh) * U_W'(rsum);
    s1_tfs_q <= TF_W'(cfg_i.thresh) * TF_W'(FS);
  end

  // stage 2: dominance and threshold compares
  always_comb begin
    ax32 = {s1_ax_q, {ONE_W{1'b0}}} - P_W'(s1_ax_q);
    ay32 = {s1_ay_q, {ONE_W{1'b0}}} - P_W'(s1_ay_q);
    asum = (SB+1)'(s1_ax_q) + (SB+1)'(s1_ay_q);
    // 32767^2 = 2^30 - 2^16 + 1
    lhs  = {asum, {(2*ONE_W){1'b0}}} - L_W'({asum, {(ONE_W+1){1'b0}}}) + L_W'(asum);
    rhs  = L_W'(s1_u_q) * L_W'(FS);
  end

  always_ff @(posedge clk_i) begin
    s2_ax_q   <= s1_ax_q;
    s2_ay_q   <= s1_ay_q;
    s2_nx_q   <= s1_nx_q;
    s2_ny_q   <= s1_ny_q;
    s2_xdom_q <= s1_pxr_q > ay32;
    s2_ydom_q <= s1_pyr_q > ax32;
    s2_xthr_q <= ax32 > P_W'(s1_tfs_q);
    s2_ythr_q <= ay32 > P_W'(s1_tfs_q);
    s2_diag_q <= lhs > rhs;
  end

  // stage 3: pick axis, diagonal or nothing
  always_comb begin
    s3_res_d = '{x: '0, y: '0, zone: ZONE_NONE};
    if (s2_xdom_q) begin
      if (s2_xthr_q) begin
        s3_res_d.x    = apply_sign(ONE_Q, s2_nx_q);
        s3_res_d.zone = ZONE_X;
      end
    end else if (s2_ydom_q) begin
      if (s2_ythr_q) begin
        s3_res_d.y    = apply_sign(ONE_Q, s2_ny_q);
        s3_res_d.zone = ZONE_Y;
      end
    end else if (s2_diag_q) begin
      s3_res_d.x    = apply_sign(DIAG_Q, s2_nx_q);
      s3_res_d.y    = apply_sign(DIAG_Q, s2_ny_q);
      s3_res_d.zone = ZONE_DIAG;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_ax_q  <= s2_ax_q;
    s3_ay_q  <= s2_ay_q;
    s3_nx_q  <= s2_nx_q;
    s3_ny_q  <= s2_ny_q;
    s3_res_q <= s3_res_d;
  end

  assign vld_o = s3_vld_q;
  assign ax_o  = s3_ax_q;
  assign ay_o  = s3_ay_q;
  assign nx_o  = s3_nx_q;
  assign ny_o  = s3_ny_q;
  assign res_o = s3_res_q;

endmodule
`default_nettype wire

>>> design/stick_deadzone_conditioner.sv
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// The pipeline holds the 31-stage square root and two 15-stage dividers.
// Reset: clears all pipeline valid bits and loads register defaults.
// Here the receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none
// ----------------------------------------------------------------------------
// stick_deadzone_conditioner
// Radial scaled deadzone or eight-way snap for one two-axis stick sample.
// ----------------------------------------------------------------------------
module stick_deadzone_conditioner #(
  parameter int unsigned SAMPLE_BITS = sdc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [SAMPLE_BITS-1:0]     raw_x_i,
  input  logic signed [SAMPLE_BITS-1:0]     raw_y_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sdc_pkg::CIDX_W-1:0]        cfg_index_i,
  input  logic [sdc_pkg::CFG_W-1:0]         cfg_data_i,
  output logic                              done_o,
  output logic signed [sdc_pkg::OUT_W-1:0]  out_x_o,
  output logic signed [sdc_pkg::OUT_W-1:0]  out_y_o,
  output logic [sdc_pkg::ZONE_W-1:0]        zone_code_o
);
  import sdc_pkg::*;

  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned FRAC   = MAGQ_W - SB;          // fraction bits of magq
  localparam int unsigned M_W    = MAGQ_W + ONE_W;       // magq * 32767
  localparam int unsigned SPL    = M_W / 2;              // product split point
  localparam int unsigned PA_W   = QUO_W + M_W - SPL;
  localparam int unsigned PB_W   = QUO_W + SPL;
  localparam int unsigned N2_W   = QUO_W + M_W;
  localparam int unsigned IFS_W  = CFG_W + SB - 1;
  localparam int unsigned SQ_SW  = EW_W + 2 + 2 * SB;
  localparam int unsigned D1_SW  = EW_W + 4 + 2 * M_W;
  localparam int unsigned MB_SW  = EW_W + 4 + 2 * QUO_W + M_W;
  localparam int unsigned D2_SW  = EW_W + 4 + 2 * QUO_W;
  localparam logic [SB-2:0] FS   = '1;

  // --------------------------------------------------------------------------
  // configuration registers
  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_IDX_MODE:   cfg_q.mode   <= cfg_data_i[0];
        CFG_IDX_INNER:  cfg_q.inner  <= cfg_data_i;
        CFG_IDX_OUTER:  cfg_q.outer  <= cfg_data_i;
        CFG_IDX_RATIO:  cfg_q.ratio  <= cfg_data_i;
        CFG_IDX_THRESH: cfg_q.thresh <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // front stage: sign and magnitude
  logic          fr_vld_q;
  logic [SB-1:0] fr_ax_q, fr_ay_q;
  logic          fr_nx_q, fr_ny_q;
  logic [SB-1:0] ux, uy;

  assign ux = $unsigned(raw_x_i);
  assign uy = $unsigned(raw_y_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_vld_q <= 1'b0;
    end else begin
      fr_vld_q <= start && !busy;
    end
  end

  // full-scale negative wraps to 2^(SB-1), which is the wanted magnitude
  always_ff @(posedge clk_i) begin
    fr_nx_q <= ux[SB-1];
    fr_ny_q <= uy[SB-1];
    fr_ax_q <= ux[SB-1] ? (~ux + 1'b1) : ux;
    fr_ay_q <= uy[SB-1] ? (~uy + 1'b1) : uy;
  end

  // --------------------------------------------------------------------------
  // eight-way snap
  logic          ew_vld;
  logic [SB-1:0] ew_ax, ew_ay;
  logic          ew_nx, ew_ny;
  ew_res_t       ew_res;

  sdc_eightway #(
    .SAMPLE_BITS (SB)
  ) u_eightway (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (fr_vld_q),
    .ax_i   (fr_ax_q),
    .ay_i   (fr_ay_q),
    .nx_i   (fr_nx_q),
    .ny_i   (fr_ny_q),
    .cfg_i  (cfg_q),
    .vld_o  (ew_vld),
    .ax_o   (ew_ax),
    .ay_o   (ew_ay),
    .nx_o   (ew_nx),
    .ny_o   (ew_ny),
    .res_o  (ew_res)
  );

  // --------------------------------------------------------------------------
  // squared magnitude
  logic              sq_vld_q;
  logic [2*SB-1:0]   sq_s_q;
  logic [SQ_SW-1:0]  sq_side_q;
  logic [2*SB-1:0]   axw, ayw;

  assign axw = (2*SB)'(ew_ax);
  assign ayw = (2*SB)'(ew_ay);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
    end else begin
      sq_vld_q <= ew_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_s_q    <= axw * axw + ayw * ayw;
    sq_side_q <= {ew_res, ew_nx, ew_ny, ew_ax, ew_ay};
  end

  // --------------------------------------------------------------------------
  // magnitude with FRAC fraction bits
  logic              rt_vld;
  logic [MAGQ_W-1:0] rt_magq;
  logic [SQ_SW-1:0]  rt_side;
  ew_res_t           rt_ew;
  logic              rt_nx, rt_ny;
  logic [SB-1:0]     rt_ax, rt_ay;

  sdc_isqrt #(
    .RAD_W  (RAD_W),
    .SIDE_W (SQ_SW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (sq_vld_q),
    .rad_i  ({sq_s_q, {(RAD_W-2*SB){1'b0}}}),
    .side_i (sq_side_q),
    .vld_o  (rt_vld),
    .root_o (rt_magq),
    .side_o (rt_side)
  );

  assign {rt_ew, rt_nx, rt_ny, rt_ax, rt_ay} = rt_side;

  // --------------------------------------------------------------------------
  // limits, zone flags and unit-vector numerators
  logic              mg_vld_q;
  logic [M_W-1:0]    mg_numx_q, mg_numy_q;
  logic [MAGQ_W-1:0] mg_magq_q;
  logic [D1_SW-1:0]  mg_side_q;
  logic [IFS_W-1:0]  inner_fs, outer_fs;
  logic [M_W-1:0]    m_val, lo_val, hi_val;
  logic [MAGQ_W-1:0] axs, ays;
  logic              dead, sat;

  always_comb begin
    inner_fs = IFS_W'(cfg_q.inner) * IFS_W'(FS);
    outer_fs = IFS_W'(cfg_q.outer) * IFS_W'(FS);
    lo_val   = {1'b0, inner_fs, {FRAC{1'b0}}};
    hi_val   = {1'b0, outer_fs, {FRAC{1'b0}}};
    m_val    = {rt_magq, {ONE_W{1'b0}}} - M_W'(rt_magq);
    axs      = {rt_ax, {FRAC{1'b0}}};
    ays      = {rt_ay, {FRAC{1'b0}}};
    dead     = (rt_magq == '0) || (m_val < lo_val);
    sat      = (cfg_q.outer <= cfg_q.inner) || (m_val > hi_val);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mg_vld_q <= 1'b0;
    end else begin
      mg_vld_q <= rt_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    mg_magq_q <= rt_magq;
    mg_numx_q <= {axs, {ONE_W{1'b0}}} - M_W'(axs);
    mg_numy_q <= {ays, {ONE_W{1'b0}}} - M_W'(ays);
    mg_side_q <= {rt_ew, rt_nx, rt_ny, dead, sat, m_val - lo_val, hi_val - lo_val};
  end

  // --------------------------------------------------------------------------
  // unit direction: a * 2^FRAC * 32767 / magq
  logic              d1_vld;
  logic [QUO_W-1:0]  d1_dx, d1_dy;
  logic [D1_SW-1:0]  d1_side;
  ew_res_t           d1_ew;
  logic              d1_nx, d1_ny, d1_dead, d1_sat;
  logic [M_W-1:0]    d1_mlo, d1_dd;

  sdc_div #(
    .NUM_W  (M_W),
    .DEN_W  (MAGQ_W),
    .QUO_W  (QUO_W),
    .SIDE_W (D1_SW)
  ) u_div_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (mg_vld_q),
    .num_a_i (mg_numx_q),
    .num_b_i (mg_numy_q),
    .den_i   (mg_magq_q),
    .side_i  (mg_side_q),
    .vld_o   (d1_vld),
    .quo_a_o (d1_dx),
    .quo_b_o (d1_dy),
    .side_o  (d1_side)
  );

  assign {d1_ew, d1_nx, d1_ny, d1_dead, d1_sat, d1_mlo, d1_dd} = d1_side;

  // --------------------------------------------------------------------------
  // scale numerator du * (m - lo), split into two partial products
  logic              ma_vld_q;
  logic [PA_W-1:0]   ma_pxa_q, ma_pya_q;
  logic [PB_W-1:0]   ma_pxb_q, ma_pyb_q;
  logic [MB_SW-1:0]  ma_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ma_vld_q <= 1'b0;
    end else begin
      ma_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    ma_pxa_q  <= PA_W'(d1_dx) * PA_W'(d1_mlo[M_W-1:SPL]);
    ma_pya_q  <= PA_W'(d1_dy) * PA_W'(d1_mlo[M_W-1:SPL]);
    ma_pxb_q  <= PB_W'(d1_dx) * PB_W'(d1_mlo[SPL-1:0]);
    ma_pyb_q  <= PB_W'(d1_dy) * PB_W'(d1_mlo[SPL-1:0]);
    ma_side_q <= {d1_ew, d1_nx, d1_ny, d1_dead, d1_sat, d1_dx, d1_dy, d1_dd};
  end

  // partial product sum
  logic              mb_vld_q;
  logic [N2_W-1:0]   mb_nx_q, mb_ny_q;
  logic [M_W-1:0]    mb_dd_q;
  logic [D2_SW-1:0]  mb_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mb_vld_q <= 1'b0;
    end else begin
      mb_vld_q <= ma_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mb_nx_q   <= {ma_pxa_q, {SPL{1'b0}}} + N2_W'(ma_pxb_q);
    mb_ny_q   <= {ma_pya_q, {SPL{1'b0}}} + N2_W'(ma_pyb_q);
    mb_dd_q   <= ma_side_q[M_W-1:0];
    mb_side_q <= ma_side_q[MB_SW-1:M_W];
  end

  // --------------------------------------------------------------------------
  // scaled output: du * (m - lo) / (hi - lo)
  logic              d2_vld;
  logic [QUO_W-1:0]  d2_qx, d2_qy;
  logic [D2_SW-1:0]  d2_side;
  ew_res_t           d2_ew;
  logic              d2_nx, d2_ny, d2_dead, d2_sat;
  logic [QUO_W-1:0]  d2_dx, d2_dy;

  sdc_div #(
    .NUM_W  (N2_W),
    .DEN_W  (M_W),
    .QUO_W  (QUO_W),
    .SIDE_W (D2_SW)
  ) u_div_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (mb_vld_q),
    .num_a_i (mb_nx_q),
    .num_b_i (mb_ny_q),
    .den_i   (mb_dd_q),
    .side_i  (mb_side_q),
    .vld_o   (d2_vld),
    .quo_a_o (d2_qx),
    .quo_b_o (d2_qy),
    .side_o  (d2_side)
  );

  assign {d2_ew, d2_nx, d2_ny, d2_dead, d2_sat, d2_dx, d2_dy} = d2_side;

  // --------------------------------------------------------------------------
  // output select and register
  logic              done_q;
  ew_res_t           res_q, res_d;

  always_comb begin
    if (cfg_q.mode) begin
      res_d = d2_ew;
    end else if (d2_dead) begin
      res_d = '{x: '0, y: '0, zone: ZONE_DEAD};
    end else if (d2_sat) begin
      res_d.x    = apply_sign(OUT_W'(d2_dx), d2_nx);
      res_d.y    = apply_sign(OUT_W'(d2_dy), d2_ny);
      res_d.zone = ZONE_SAT;
    end else begin
      res_d.x    = apply_sign(OUT_W'(d2_qx), d2_nx);
      res_d.y    = apply_sign(OUT_W'(d2_qy), d2_ny);
      res_d.zone = ZONE_SCALED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o      = done_q;
  assign out_x_o     = $signed(res_q.x);
  assign out_y_o     = $signed(res_q.y);
  assign zone_code_o = res_q.zone;

endmodule
`default_nettype wire
